[hw/rtl/sitda_pkg.sv]
// Shared types and constants for the signed integer to decimal text unit.
`default_nettype none
package sitda_pkg;

  localparam int CHAR_W = 6;
  localparam int BCD_W  = 4;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [BCD_W-1:0]  bcd_t;

  localparam char_t CHAR_ZERO  = 6'd48;
  localparam char_t CHAR_MINUS = 6'd45;

  localparam bcd_t BCD_ADJ_LIMIT = 4'd5;
  localparam bcd_t BCD_ADJ       = 4'd3;

  // floor(width * log10(2)) + 1, enough decimal digits for any width-bit magnitude
  function automatic int digit_count(input int width);
    return ((width * 1233) >> 12) + 1;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/sitda_value_if.sv]
// Input channel carrying one signed integer per beat.
`default_nettype none
interface sitda_value_if #(
  parameter int VALUE_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

[hw/rtl/sitda_char_if.sv]
// Output channel carrying one ASCII character per beat.
`default_nettype none
interface sitda_char_if
  import sitda_pkg::*;
();
  logic  valid;
  logic  ready;
  char_t text_char;
  logic  last;

  modport source (output valid, output text_char, output last, input ready);
  modport sink   (input valid, input text_char, input last, output ready);
endinterface
`default_nettype wire

[hw/rtl/sitda_front.sv]
// Front end: takes a number, splits sign and magnitude, converts to BCD by shift-add-3.
`default_nettype none
module sitda_front
  import sitda_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int NUM_DIGITS  = 10,
  parameter int TOP_W       = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  sitda_value_if.sink                       number,
  output logic                              push_valid,
  input  logic                              push_ready,
  output logic [1+TOP_W+BCD_W*NUM_DIGITS-1:0] push_data
);

  localparam int BW = BCD_W * NUM_DIGITS;
  localparam int CW = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [1:0] {IDLE, CONV, DONE} state_t;

  state_t                 state;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] bin;
  logic [BW-1:0]          bcd;
  logic [CW-1:0]          cnt;
  logic [BW-1:0]          adj;
  logic [BW-1:0]          bcd_next;
  logic [TOP_W-1:0]       top;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[BCD_W*i +: BCD_W] = (bcd[BCD_W*i +: BCD_W] >= BCD_ADJ_LIMIT)
                              ? bcd[BCD_W*i +: BCD_W] + BCD_ADJ
                              : bcd[BCD_W*i +: BCD_W];
    end
    bcd_next = {adj[BW-2:0], bin[VALUE_WIDTH-1]};
  end

  always_comb begin
    top = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[BCD_W*i +: BCD_W] != '0) begin
        top = TOP_W'(i);
      end
    end
  end

  assign number.ready = (state == IDLE);
  assign push_valid   = (state == DONE);
  assign push_data    = {neg, top, bcd};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (number.valid) begin
            neg   <= number.value[VALUE_WIDTH-1];
            bin   <= number.value[VALUE_WIDTH-1]
                     ? (~number.value + VALUE_WIDTH'(1))
                     : number.value;
            bcd   <= '0;
            cnt   <= CW'(VALUE_WIDTH);
            state <= CONV;
          end
        end
        CONV: begin
          bcd <= bcd_next;
          bin <= {bin[VALUE_WIDTH-2:0], 1'b0};
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (push_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sitda_queue.sv]
// Two-entry queue between the converter and the character emitter.
`default_nettype none
module sitda_queue #(
  parameter int DATA_W = 46
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  logic [DATA_W-1:0] mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sitda_back.sv]
// Back end: emits the sign and the digits of one number, most significant first.
`default_nettype none
module sitda_back
  import sitda_pkg::*;
#(
  parameter int NUM_DIGITS = 10,
  parameter int TOP_W      = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  logic [1+TOP_W+BCD_W*NUM_DIGITS-1:0] pop_data,
  sitda_char_if.source                        text
);

  localparam int BW = BCD_W * NUM_DIGITS;

  logic             busy;
  logic             sign_pend;
  logic [TOP_W-1:0] idx;
  logic [BW-1:0]    digits;
  logic             advance;
  bcd_t             cur;

  assign pop_ready = !busy;
  assign advance   = !text.valid || text.ready;
  assign cur       = digits[idx*BCD_W +: BCD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      sign_pend  <= 1'b0;
      text.valid <= 1'b0;
    end else begin
      if (!busy) begin
        if (pop_valid) begin
          busy      <= 1'b1;
          sign_pend <= pop_data[TOP_W+BW];
          idx       <= pop_data[BW +: TOP_W];
          digits    <= pop_data[BW-1:0];
        end
        if (advance) begin
          text.valid <= 1'b0;
        end
      end else if (advance) begin
        text.valid <= 1'b1;
        if (sign_pend) begin
          text.text_char <= CHAR_MINUS;
          text.last      <= 1'b0;
          sign_pend      <= 1'b0;
        end else begin
          text.text_char <= CHAR_ZERO + char_t'(cur);
          text.last      <= (idx == '0);
          if (idx == '0) begin
            busy <= 1'b0;
          end else begin
            idx <= idx - TOP_W'(1);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/signed_int_to_decimal_ascii_unit.sv]
// Top level of the signed integer to decimal ASCII text unit.
// Converts each VALUE_WIDTH-bit two's-complement number into its decimal text, one
// character per output beat, most significant digit first, with a leading '-' for
// negative numbers and last set on the final digit; zero gives a single '0'. The
// converter loads a number, performs one shift-add-3 step per input bit, then hands
// the result to the queue, waiting while the queue is full. The emitter loads a
// queued entry, then sends one character per cycle while the output is not stalled,
// and a two-entry queue between them lets conversion of the next number overlap
// emission of the current one.
`default_nettype none
module signed_int_to_decimal_ascii_unit
  import sitda_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  sitda_value_if.sink  number,
  sitda_char_if.source text
);

  localparam int NUM_DIGITS = digit_count(VALUE_WIDTH);
  localparam int TOP_W      = $clog2(NUM_DIGITS);
  localparam int QW         = 1 + TOP_W + BCD_W * NUM_DIGITS;

  logic          push_valid;
  logic          push_ready;
  logic [QW-1:0] push_data;
  logic          pop_valid;
  logic          pop_ready;
  logic [QW-1:0] pop_data;

  sitda_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS),
    .TOP_W       (TOP_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .number     (number),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sitda_queue #(
    .DATA_W (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sitda_back #(
    .NUM_DIGITS (NUM_DIGITS),
    .TOP_W      (TOP_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .text      (text)
  );

`ifndef SYNTH
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    text.valid && text.text_char == CHAR_MINUS |-> !text.last)
    else $error("minus sign marked as last character");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    text.valid |-> text.text_char == CHAR_MINUS ||
                   (text.text_char >= CHAR_ZERO && text.text_char <= CHAR_ZERO + 6'd9))
    else $error("character outside sign and digit range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    number.valid && number.ready |=> !number.ready)
    else $error("converter ready again straight after accepting a beat");
`endif

endmodule
`default_nettype wire

[tb/sv/tb_signed_int_to_decimal_ascii_unit.sv]
`timescale 1ns / 100ps
// Testbench for the signed integer to decimal ASCII unit: corner and random numbers.
module tb_signed_int_to_decimal_ascii_unit
  import sitda_pkg::*;
();

  localparam int VALUE_WIDTH   = 32;
  localparam int RADIX         = 10;
  localparam int SETTLE_CYCLES = 2 * (VALUE_WIDTH + 2);
  localparam int RANDOM_COUNT  = 120;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef struct packed {
    char_t text_char;
    logic  last;
  } text_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sitda_value_if #(.VALUE_WIDTH(VALUE_WIDTH)) number_ch ();
  sitda_char_if text_ch ();

  signed_int_to_decimal_ascii_unit #(.VALUE_WIDTH(VALUE_WIDTH)) u_top (
    .clk(clk),
    .rst(rst),
    .number(number_ch),
    .text(text_ch)
  );

  value_t     pending_values[$];
  text_beat_t expected_text[$];
  int         send_idle_pct  = 0;
  int         recv_idle_pct  = 0;
  logic       value_taken    = 1'b0;
  int         errors         = 0;
  int         values_sent    = 0;
  int         negatives_sent = 0;
  int         chars_checked  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic void spell_value(input value_t v);
    logic [VALUE_WIDTH-1:0] mag;
    bcd_t                   digits[$];
    text_beat_t             beat;
    mag = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
    do begin
      digits.push_front(bcd_t'(mag % RADIX));
      mag = mag / RADIX;
    end while (mag != 0);
    if (v[VALUE_WIDTH-1]) begin
      beat.text_char = CHAR_MINUS;
      beat.last      = 1'b0;
      expected_text.push_back(beat);
    end
    for (int i = 0; i < digits.size(); i++) begin
      beat.text_char = char_t'(CHAR_ZERO + digits[i]);
      beat.last      = (i == digits.size() - 1);
      expected_text.push_back(beat);
    end
  endfunction

  function automatic value_t random_value();
    longint unsigned scale;
    value_t          v;
    scale = 1;
    case ($urandom_range(3))
      0: v = $urandom();
      1: begin
        repeat ($urandom_range(9, 1)) scale = scale * RADIX;
        v = value_t'($urandom() % scale);
        if ($urandom_range(1)) v = -v;
      end
      2: begin
        v = value_t'($urandom_range(20));
        if ($urandom_range(1)) v = -v;
      end
      default: begin
        if ($urandom_range(1)) v = 32'h7FFF_FFFF - $urandom_range(15);
        else v = 32'h8000_0000 + $urandom_range(15);
      end
    endcase
    return v;
  endfunction

  // accept input beats and predict their text
  always @(posedge clk) begin
    value_taken <= !rst && number_ch.valid && number_ch.ready;
    if (!rst && number_ch.valid && number_ch.ready) begin
      spell_value(number_ch.value);
      values_sent++;
      if (number_ch.value < 0) negatives_sent++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      number_ch.valid <= 1'b0;
      number_ch.value <= '0;
      text_ch.ready   <= 1'b0;
    end else begin
      text_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!number_ch.valid || value_taken) begin
        if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          number_ch.valid <= 1'b1;
          number_ch.value <= pending_values.pop_front();
        end else begin
          number_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : text_monitor
    text_beat_t want;
    if (!rst && text_ch.valid && text_ch.ready) begin
      if (expected_text.size() == 0) begin
        report_mismatch("unexpected character", int'(text_ch.text_char), 0);
      end else begin
        want = expected_text.pop_front();
        if (text_ch.text_char !== want.text_char)
          report_mismatch("text_char", int'(text_ch.text_char), int'(want.text_char));
        if (text_ch.last !== want.last)
          report_mismatch("last", int'(text_ch.last), int'(want.last));
        chars_checked++;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 78;
          pending_values = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
                             999999999, -999999999, 1000000000, -1000000000,
                             1234567890, -1234567890, 32'h5555_5555, 32'hAAAA_AAAA,
                             32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFE};
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (RANDOM_COUNT) pending_values.push_back(random_value());
      while (pending_values.size() != 0 || number_ch.valid || expected_text.size() != 0)
        @(posedge clk);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Converted %0d numbers (%0d negative), checked %0d characters", values_sent,
             negatives_sent, chars_checked);
    $display("across three back-pressure phases, %0d mismatches", errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Run timed out");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
